/* hdl/bblc_pkg.sv */
// shared types and constants for the byte budget lru tile cache
// no dependencies
package bblc_pkg;

    localparam int unsigned KEY_W   = 99;
    localparam int unsigned BYTES_W = 26;
    localparam int unsigned HAND_W  = 16;
    localparam int unsigned TOT_W   = 40;
    localparam logic [29:0] BYTES_MAX = 30'h3FFF_FFFF;

    localparam logic [2:0] MODE_LOOKUP = 3'd0;
    localparam logic [2:0] MODE_BEST   = 3'd1;
    localparam logic [2:0] MODE_INSERT = 3'd2;
    localparam logic [2:0] MODE_INVAL  = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam logic [2:0] TIER_MAX = 3'd4;

    // apb register addresses
    localparam logic [1:0] REG_BUDGET = 2'd0;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              match_en;
        logic [KEY_W-1:0]  key;
        logic              doc_en;
        logic              touch;
        logic              evict_oldest;
        logic              write_free;
        logic              update_hit;
        logic              clear;
        logic [BYTES_W-1:0] bytes;
        logic [HAND_W-1:0]  handle;
    } cell_cmd_t;

    function automatic logic [2:0] best_tier(input logic [2:0] step);
        logic [2:0] t;
        begin
            unique case (step)
                3'd0: t = 3'd2;
                3'd1: t = 3'd1;
                3'd2: t = 3'd3;
                3'd3: t = 3'd0;
                default: t = 3'd4;
            endcase
            return t;
        end
    endfunction

endpackage

/* hdl/bblc_cell.sv */
// one entry of the tile table: key, size, handle, recency rank
// depends on bblc_pkg
module bblc_cell #(
    parameter int unsigned RANK_W = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bblc_pkg::cell_cmd_t       cmd,
    input  logic [RANK_W-1:0]         hit_rank,
    input  logic                      hit_any,
    input  logic [RANK_W-1:0]         old_rank,
    input  logic                      sel_free,
    output logic                      valid,
    output logic                      match,
    output logic                      doc_match,
    output logic [RANK_W-1:0]         rank,
    output logic [bblc_pkg::BYTES_W-1:0] size,
    output logic [bblc_pkg::HAND_W-1:0]  handle,
    output logic [2:0]                tier
);
    import bblc_pkg::*;

    logic              valid_reg, valid_next;
    logic [KEY_W-1:0]  key_reg;
    logic [BYTES_W-1:0] size_reg;
    logic [HAND_W-1:0] hand_reg;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              is_old;

    assign valid     = valid_reg;
    assign rank      = rank_reg;
    assign size      = size_reg;
    assign handle    = hand_reg;
    assign tier      = key_reg[2:0];
    assign match     = valid_reg && cmd.match_en && (key_reg == cmd.key);
    assign doc_match = valid_reg && cmd.doc_en && (key_reg[18:3] == cmd.key[18:3]);
    assign is_old    = valid_reg && (rank_reg == old_rank);

    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (cmd.clear) begin
            valid_next = 1'b0;
        end else if (cmd.touch && hit_any) begin
            if (match || (cmd.update_hit && match)) begin
                rank_next = '0;
            end else if (valid_reg && rank_reg < hit_rank) begin
                rank_next = rank_reg + 1'b1;
            end
        end else if (cmd.evict_oldest) begin
            if (is_old) begin
                valid_next = 1'b0;
            end else if (valid_reg && rank_reg > old_rank) begin
                rank_next = rank_reg - 1'b1;
            end
        end else if (cmd.write_free) begin
            if (sel_free) begin
                valid_next = 1'b1;
                rank_next  = '0;
            end else if (valid_reg) begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        rank_reg <= rank_next;
        if (cmd.write_free && sel_free) begin
            key_reg  <= cmd.key;
            size_reg <= cmd.bytes;
            hand_reg <= cmd.handle;
        end else if (cmd.update_hit && match) begin
            size_reg <= cmd.bytes;
            hand_reg <= cmd.handle;
        end
    end

endmodule

/* hdl/byte_budget_lru_tile_cache_unit.sv */
// top level of the byte budget lru tile cache: controller, apb register, cell row
// depends on bblc_pkg and bblc_cell
// path to result: lookup, clear, insert of a known key and ignored requests pass find and out,
// best tier lookup tries tiers 2, 1, 3, 0, 4 in turn until a hit, insert of a new key
// passes evict and write, invalidate removes every matching entry in inval
// one request at a time, the next one taken in idle once the result has loaded in out
// reset (synchronous, aresetn low) empties the table and sets the budget to 268435456
module byte_budget_lru_tile_cache_unit #(
    parameter int unsigned ENTRY_COUNT = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode, doc_id, page_no, x_norm, y_norm, w_norm, h_norm, tier, entry_bytes, payload
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit, found_payload, found_tier, removed_count, bytes_in_use, entries_in_use
    output logic [63:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import bblc_pkg::*;

    localparam int unsigned RANK_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int unsigned IDX_W  = RANK_W;
    localparam int unsigned CNT_W  = $clog2(ENTRY_COUNT + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FIND  = 7'b0000010,
        ST_BEST  = 7'b0000100,
        ST_EVICT = 7'b0001000,
        ST_INVAL = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] budget_reg;
    logic [143:0] req_reg;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic [2:0] step_reg, step_next;
    logic hit_reg, hit_next;
    logic [HAND_W-1:0] fpay_reg, fpay_next;
    logic [2:0] ftier_reg, ftier_next;
    logic [63:0] out_reg;
    logic out_valid_reg;

    logic [2:0]  r_mode;
    logic [95:0] r_key6;
    logic [2:0]  r_tier;
    logic [BYTES_W-1:0] r_bytes;
    logic [HAND_W-1:0]  r_pay;

    cell_cmd_t cmd;
    logic [ENTRY_COUNT-1:0] c_valid, c_match, c_doc, sel_free;
    logic [RANK_W-1:0] c_rank [ENTRY_COUNT];
    logic [BYTES_W-1:0] c_size [ENTRY_COUNT];
    logic [HAND_W-1:0] c_hand [ENTRY_COUNT];
    logic [2:0] c_tier [ENTRY_COUNT];

    logic hit_any, doc_any, free_any;
    logic [RANK_W-1:0] hit_rank;
    logic [BYTES_W-1:0] hit_size, old_size, doc_size;
    logic [HAND_W-1:0] hit_hand;
    logic [2:0] hit_tier;
    logic [CNT_W-1:0] n_valid;
    logic [RANK_W-1:0] old_rank;
    logic [RANK_W-1:0] doc_rank, drop_rank;

    assign r_mode  = req_reg[2:0];
    assign r_key6  = req_reg[98:3];
    assign r_tier  = req_reg[101:99];
    assign r_bytes = req_reg[127:102];
    assign r_pay   = req_reg[143:128];

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BUDGET) ? budget_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= 32'd268435456;
        end else if (psel && penable && pwrite && paddr == REG_BUDGET) begin
            budget_reg <= pwdata;
        end
    end

    // cell row
    for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
        bblc_cell #(.RANK_W(RANK_W)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
            .hit_rank(hit_rank), .hit_any(hit_any), .old_rank(drop_rank),
            .sel_free(sel_free[g]), .valid(c_valid[g]), .match(c_match[g]),
            .doc_match(c_doc[g]), .rank(c_rank[g]), .size(c_size[g]),
            .handle(c_hand[g]), .tier(c_tier[g])
        );
    end

    always_comb begin
        logic found;
        logic dfound;
        logic ffound;
        hit_any = 1'b0; hit_rank = '0; hit_size = '0; hit_hand = '0; hit_tier = '0;
        doc_any = 1'b0; doc_size = '0; doc_rank = '0;
        free_any = 1'b0; sel_free = '0;
        old_size = '0; n_valid = '0;
        found = 1'b0; dfound = 1'b0; ffound = 1'b0;
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (c_match[i] && !found) begin
                found = 1'b1;
                hit_rank = c_rank[i]; hit_size = c_size[i];
                hit_hand = c_hand[i]; hit_tier = c_tier[i];
            end
            if (c_doc[i] && !dfound) begin
                dfound = 1'b1;
                doc_rank = c_rank[i];
                doc_size = c_size[i];
            end
            if (!c_valid[i] && !ffound) begin
                ffound = 1'b1;
                sel_free[i] = 1'b1;
            end
            if (c_valid[i] && c_rank[i] == old_rank) begin
                old_size = c_size[i];
            end
            n_valid = n_valid + CNT_W'(c_valid[i]);
        end
        hit_any = found; doc_any = dfound; free_any = ffound;
    end

    // oldest valid entry has rank count-1
    assign old_rank = RANK_W'(n_valid - 1'b1);
    // invalidate drops the first matching entry by its rank
    assign drop_rank = (state_reg == ST_INVAL) ? doc_rank : old_rank;

    logic need_evict;
    assign need_evict = (n_valid != '0) &&
        ((total_reg + TOT_W'(r_bytes) > TOT_W'(budget_reg)) ||
         (n_valid >= CNT_W'(ENTRY_COUNT)));

    always_comb begin
        cmd = '0;
        cmd.key    = {r_key6, r_tier};
        cmd.bytes  = r_bytes;
        cmd.handle = r_pay;
        state_next = state_reg;
        total_next = total_reg;
        removed_next = removed_reg;
        step_next = step_reg;
        hit_next = hit_reg; fpay_next = fpay_reg; ftier_next = ftier_reg;
        unique case (state_reg)
            ST_IDLE: begin
                hit_next = 1'b0; fpay_next = '0; ftier_next = '0;
                removed_next = '0; step_next = '0;
                if (s_tvalid) state_next = ST_FIND;
            end
            ST_FIND: begin
                cmd.match_en = 1'b1;
                if (r_mode == MODE_LOOKUP) begin
                    if (r_tier <= TIER_MAX) begin
                        cmd.touch = 1'b1;
                        hit_next = hit_any; fpay_next = hit_any ? hit_hand : '0;
                        ftier_next = hit_any ? hit_tier : '0;
                    end else begin
                        cmd.match_en = 1'b0;
                    end
                    state_next = ST_OUT;
                end else if (r_mode == MODE_BEST) begin
                    state_next = ST_BEST;
                    cmd.match_en = 1'b0;
                end else if (r_mode == MODE_INSERT) begin
                    if (r_pay == '0 || r_tier > TIER_MAX) begin
                        cmd.match_en = 1'b0;
                        state_next = ST_OUT;
                    end else if (hit_any) begin
                        cmd.touch = 1'b1; cmd.update_hit = 1'b1;
                        total_next = total_reg - TOT_W'(hit_size) + TOT_W'(r_bytes);
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_EVICT;
                    end
                end else if (r_mode == MODE_INVAL) begin
                    cmd.match_en = 1'b0;
                    state_next = ST_INVAL;
                end else if (r_mode == MODE_CLEAR) begin
                    cmd.match_en = 1'b0;
                    cmd.clear = 1'b1;
                    removed_next = n_valid;
                    total_next = '0;
                    state_next = ST_OUT;
                end else begin
                    cmd.match_en = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_BEST: begin
                cmd.match_en = 1'b1;
                cmd.key = {r_key6, best_tier(step_reg)};
                cmd.touch = 1'b1;
                if (hit_any) begin
                    hit_next = 1'b1; fpay_next = hit_hand; ftier_next = hit_tier;
                    state_next = ST_OUT;
                end else if (step_reg == 3'd4) begin
                    state_next = ST_OUT;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_EVICT: begin
                if (need_evict) begin
                    cmd.evict_oldest = 1'b1;
                    total_next = total_reg - TOT_W'(old_size);
                    removed_next = removed_reg + 1'b1;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (free_any) begin
                    cmd.write_free = 1'b1;
                    total_next = total_reg + TOT_W'(r_bytes);
                end
                state_next = ST_OUT;
            end
            ST_INVAL: begin
                cmd.doc_en = 1'b1;
                if (doc_any) begin
                    // remove one entry a cycle, lowest index first
                    cmd.key = {r_key6, r_tier};
                    cmd.evict_oldest = 1'b1;
                    total_next = total_reg - TOT_W'(doc_size);
                    removed_next = removed_reg + 1'b1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            if (state_reg == ST_OUT && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) req_reg <= s_tdata;
        removed_reg <= removed_next;
        step_reg <= step_next;
        hit_reg <= hit_next; fpay_reg <= fpay_next; ftier_reg <= ftier_next;
        if (state_reg == ST_OUT && (!out_valid_reg || m_tready)) begin
            out_reg <= {4'd0,
                        (n_valid > CNT_W'(31)) ? 5'd31 : 5'(n_valid),
                        (total_reg > TOT_W'(BYTES_MAX)) ? BYTES_MAX : total_reg[29:0],
                        (removed_reg > CNT_W'(31)) ? 5'd31 : 5'(removed_reg),
                        ftier_reg, fpay_reg, hit_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

/* hdl/bblc_checker.sv */
// port-level checks for the tile cache unit
// depends on byte_budget_lru_tile_cache_unit ports
module bblc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0) else $error("payload on miss");
    a_ent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[59:55] <= 5'd31) else $error("entry count");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("accepted twice");
endmodule

bind byte_budget_lru_tile_cache_unit bblc_checker u_bblc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
